[hdl/fts_pkg.sv]
// Shared types and constants of the FCFS task scheduler.
`default_nettype none

package fts_pkg;

  localparam int MaxTasksDef = 16;
  localparam logic [30:0] WaitMax = '1;
  localparam logic [31:0] TickMax = '1;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_KILL = 2'd1,
    ACT_TICK = 2'd2,
    ACT_READ = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_READY  = 3'd0,
    ST_RUN    = 3'd1,
    ST_IO     = 3'd2,
    ST_DONE   = 3'd3,
    ST_KILLED = 3'd4
  } slot_st_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_PICK,
    OP_KILL,
    OP_EXEC,
    OP_AGE
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PICK1,
    S_EXEC,
    S_AGE,
    S_PICK2,
    S_KILL,
    S_RESP
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    logic [15:0]        pid;
    logic [15:0]        burst;
    logic signed [16:0] io_start;
    logic [15:0]        io_dur;
    logic [31:0]        tick;
    logic               ran;
  } cmd_t;

  // carried from cell to cell along with the sweep token
  typedef struct packed {
    logic found;
    logic rel;
  } chain_t;

  typedef struct packed {
    logic ran;
    logic fin;
  } exec_ev_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] cpu;
    logic [15:0] io;
    logic [31:0] comp;
    logic [30:0] wait_cnt;
    slot_st_e    st;
  } view_t;

endpackage

`default_nettype wire

[hdl/fts_cell.sv]
// One task slot of the scheduler chain.
`default_nettype none

module fts_cell #(
  parameter int MaxTasks = fts_pkg::MaxTasksDef,
  parameter int Idx      = 0,
  localparam int IW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1,
  localparam int CW = $clog2(MaxTasks + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  fts_pkg::cell_op_e      op_i,
  input  fts_pkg::cmd_t          cmd_i,
  input  wire logic [CW-1:0]     count_i,
  input  wire logic [IW-1:0]     holder_i,
  input  wire logic              hv_i,
  input  wire logic              tok_i,
  input  fts_pkg::chain_t        chain_i,
  input  wire logic [IW-1:0]     idx_i,
  output logic                   tok_o,
  output fts_pkg::chain_t        chain_o,
  output logic [IW-1:0]          idx_o,
  output fts_pkg::exec_ev_t      ev_o,
  output fts_pkg::view_t         view_o,
  output logic                   settled_o,
  output logic                   running_o
);

  logic [15:0]        pid_q, pid_d;
  logic [15:0]        burst_q, burst_d;
  logic signed [16:0] ios_q, ios_d;
  logic [15:0]        iod_q, iod_d;
  logic [15:0]        left_q, left_d;
  logic [15:0]        done_q, done_d;
  logic [15:0]        iol_q, iol_d;
  logic [31:0]        comp_q, comp_d;
  logic [30:0]        wait_q, wait_d;
  fts_pkg::slot_st_e  st_q, st_d;
  logic               tok_q, tok_d;
  fts_pkg::chain_t    chain_q, chain_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic               valid;
  logic               is_h;

  assign valid = CW'(Idx) < count_i;
  assign is_h  = hv_i && (holder_i == IW'(Idx));

  always_comb begin
    pid_d   = pid_q;
    burst_d = burst_q;
    ios_d   = ios_q;
    iod_d   = iod_q;
    left_d  = left_q;
    done_d  = done_q;
    iol_d   = iol_q;
    comp_d  = comp_q;
    wait_d  = wait_q;
    st_d    = st_q;
    tok_d   = tok_i;
    chain_d = chain_i;
    idx_d   = idx_i;
    ev_o    = '0;
    case (op_i)
      fts_pkg::OP_LOAD: begin
        if (count_i == CW'(Idx)) begin
          pid_d   = cmd_i.pid;
          burst_d = cmd_i.burst;
          ios_d   = cmd_i.io_start;
          iod_d   = cmd_i.io_dur;
          left_d  = cmd_i.burst;
          done_d  = '0;
          iol_d   = cmd_i.io_dur;
          comp_d  = '0;
          wait_d  = '0;
          st_d    = fts_pkg::ST_READY;
        end
      end
      fts_pkg::OP_PICK: begin
        if (tok_i && valid && st_q == fts_pkg::ST_READY && left_q != '0 &&
            !chain_i.found) begin
          st_d          = fts_pkg::ST_RUN;
          chain_d.found = 1'b1;
          idx_d         = IW'(Idx);
        end
      end
      fts_pkg::OP_KILL: begin
        if (tok_i && valid && pid_q == cmd_i.pid && !chain_i.found) begin
          chain_d.found = 1'b1;
          if (st_q inside {fts_pkg::ST_READY, fts_pkg::ST_RUN, fts_pkg::ST_IO}) begin
            st_d   = fts_pkg::ST_KILLED;
            comp_d = cmd_i.tick;
            left_d = '0;
            if (is_h) chain_d.rel = 1'b1;
          end
        end
      end
      fts_pkg::OP_EXEC: begin
        if (valid && is_h) begin
          if (left_q != '0) begin
            if (!ios_q[16] && ios_q[15:0] == done_q && iol_q != '0) begin
              st_d = fts_pkg::ST_IO;
            end else begin
              st_d   = fts_pkg::ST_RUN;
              ev_o.ran = 1'b1;
              left_d = left_q - 16'd1;
              done_d = done_q + 16'd1;
              if (left_q == 16'd1) begin
                st_d     = fts_pkg::ST_DONE;
                comp_d   = (cmd_i.tick == fts_pkg::TickMax) ? fts_pkg::TickMax
                                                            : cmd_i.tick + 32'd1;
                ev_o.fin = 1'b1;
              end
            end
          end else begin
            st_d     = fts_pkg::ST_DONE;
            comp_d   = cmd_i.tick;
            ev_o.fin = 1'b1;
          end
        end
      end
      fts_pkg::OP_AGE: begin
        if (valid) begin
          if (st_q == fts_pkg::ST_READY && !is_h && cmd_i.ran &&
              wait_q != fts_pkg::WaitMax) begin
            wait_d = wait_q + 31'd1;
          end
          // count down I/O, release to ready on the last tick
          if (st_q == fts_pkg::ST_IO) begin
            if (iol_q != '0) begin
              iol_d = iol_q - 16'd1;
              if (iol_q == 16'd1) st_d = fts_pkg::ST_READY;
            end else begin
              st_d = fts_pkg::ST_READY;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pid_q   <= pid_d;
    burst_q <= burst_d;
    ios_q   <= ios_d;
    iod_q   <= iod_d;
    left_q  <= left_d;
    done_q  <= done_d;
    iol_q   <= iol_d;
    comp_q  <= comp_d;
    wait_q  <= wait_d;
    st_q    <= st_d;
    idx_q   <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      chain_q <= '0;
    end else begin
      tok_q   <= tok_d;
      chain_q <= chain_d;
    end
  end

  assign tok_o   = tok_q;
  assign chain_o = chain_q;
  assign idx_o   = idx_q;

  assign view_o.pid      = pid_q;
  assign view_o.cpu      = burst_q;
  assign view_o.io       = iod_q;
  assign view_o.comp     = comp_q;
  assign view_o.wait_cnt = wait_q;
  assign view_o.st       = st_q;

  assign settled_o = !valid || st_q == fts_pkg::ST_DONE || st_q == fts_pkg::ST_KILLED;
  assign running_o = valid && st_q == fts_pkg::ST_RUN;

endmodule

`default_nettype wire

[hdl/fcfs_task_scheduler_with_io_and_kill_top.sv]
// First-come-first-served task scheduler: controller and the chain of slots.
//
// One input word carries an action (load, kill by pid, tick, read slot) and
// its fields; every input word yields exactly one result word holding the
// status, holder slot, all-done flag, tick count and, for a read, the slot's
// statistics. Both channels are valid/ready.
// A load passes S_LOAD and then S_RESP, a read goes straight to S_RESP and a
// kill sweeps the chain in S_KILL. A tick runs S_EXEC and S_AGE when the CPU
// is held, adds S_PICK2 when the CPU is still free or its holder finishes,
// and starts with S_PICK1 when no holder is held. Each pick or kill is a
// token that walks the slot chain one cell per cycle.
// One word is in work at a time; in_ready_o is high only while idle, so the
// next word is taken only after the result is registered.
// Results sit in an output register, so a new word is taken while the last
// result still waits; a stalled receiver holds the next result and the
// block waits with it.
// Reset empties the table, frees the CPU and clears the tick count; slot
// contents are written on load and need no clearing.
`default_nettype none

module fcfs_task_scheduler_with_io_and_kill_top #(
  parameter int MaxTasks = fts_pkg::MaxTasksDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [15:0]       task_pid_i,
  input  wire logic [15:0]       cpu_burst_i,
  input  wire logic signed [16:0] io_start_i,
  input  wire logic [15:0]       io_duration_i,
  input  wire logic [3:0]        read_slot_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   ok_o,
  output logic                   cpu_held_o,
  output logic [3:0]             holder_slot_o,
  output logic                   all_done_o,
  output logic [31:0]            tick_now_o,
  output logic [15:0]            entry_pid_o,
  output logic [15:0]            entry_cpu_o,
  output logic [15:0]            entry_io_o,
  output logic signed [31:0]     entry_turnaround_o,
  output logic [30:0]            entry_waiting_o,
  output logic [2:0]             entry_status_o
);

  localparam int IW   = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CW   = $clog2(MaxTasks + 1);
  localparam int CmpW = (CW > 4) ? CW : 4;

  typedef struct packed {
    logic               ok;
    logic               held;
    logic [3:0]         hslot;
    logic               all_done;
    logic [31:0]        tick;
    logic [15:0]        pid;
    logic [15:0]        cpu;
    logic [15:0]        io;
    logic signed [31:0] ta;
    logic [30:0]        waiting;
    logic [2:0]         st;
  } res_t;

  fts_pkg::state_e    state_q, state_d;
  fts_pkg::act_e      act_q, act_d;
  logic [15:0]        pid_q, pid_d;
  logic [15:0]        burst_q, burst_d;
  logic signed [16:0] ios_q, ios_d;
  logic [15:0]        iod_q, iod_d;
  logic [3:0]         rs_q, rs_d;
  logic [CW-1:0]      count_q, count_d;
  logic [IW-1:0]      holder_q, holder_d;
  logic               hv_q, hv_d;
  logic [31:0]        tick_q, tick_d;
  logic               tok_q, tok_d;
  logic               ran_q, ran_d;
  logic               fin_q, fin_d;
  logic               ok_q, ok_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  fts_pkg::cell_op_e  op;
  fts_pkg::cmd_t      cmd;
  logic               tok   [MaxTasks+1];
  fts_pkg::chain_t    chain [MaxTasks+1];
  logic [IW-1:0]      idx   [MaxTasks+1];
  fts_pkg::exec_ev_t  ev    [MaxTasks];
  fts_pkg::view_t     view  [MaxTasks];
  logic [MaxTasks-1:0] ran_vec, fin_vec, settled_vec, run_vec;
  logic [MaxTasks:0]  tok_vec;
  logic [IW-1:0]      rs_idx;
  logic               rd_ok;
  fts_pkg::view_t     rd_view;

  assign tok[0]   = tok_q;
  assign chain[0] = '0;
  assign idx[0]   = '0;

  assign cmd.pid      = pid_q;
  assign cmd.burst    = burst_q;
  assign cmd.io_start = ios_q;
  assign cmd.io_dur   = iod_q;
  assign cmd.tick     = tick_q;
  assign cmd.ran      = ran_q;

  for (genvar k = 0; k < MaxTasks; k++) begin : g_cell
    fts_cell #(
      .MaxTasks(MaxTasks),
      .Idx     (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .op_i     (op),
      .cmd_i    (cmd),
      .count_i  (count_q),
      .holder_i (holder_q),
      .hv_i     (hv_q),
      .tok_i    (tok[k]),
      .chain_i  (chain[k]),
      .idx_i    (idx[k]),
      .tok_o    (tok[k+1]),
      .chain_o  (chain[k+1]),
      .idx_o    (idx[k+1]),
      .ev_o     (ev[k]),
      .view_o   (view[k]),
      .settled_o(settled_vec[k]),
      .running_o(run_vec[k])
    );
    assign ran_vec[k] = ev[k].ran;
    assign fin_vec[k] = ev[k].fin;
  end

  for (genvar k = 0; k <= MaxTasks; k++) begin : g_tok
    assign tok_vec[k] = tok[k];
  end

  always_comb begin
    case (state_q)
      fts_pkg::S_LOAD:  op = fts_pkg::OP_LOAD;
      fts_pkg::S_PICK1: op = fts_pkg::OP_PICK;
      fts_pkg::S_PICK2: op = fts_pkg::OP_PICK;
      fts_pkg::S_KILL:  op = fts_pkg::OP_KILL;
      fts_pkg::S_EXEC:  op = fts_pkg::OP_EXEC;
      fts_pkg::S_AGE:   op = fts_pkg::OP_AGE;
      default:          op = fts_pkg::OP_NOP;
    endcase
  end

  assign rs_idx  = IW'(rs_q);
  assign rd_ok   = CmpW'(rs_q) < CmpW'(count_q);
  assign rd_view = view[rs_idx];

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    pid_d       = pid_q;
    burst_d     = burst_q;
    ios_d       = ios_q;
    iod_d       = iod_q;
    rs_d        = rs_q;
    count_d     = count_q;
    holder_d    = holder_q;
    hv_d        = hv_q;
    tick_d      = tick_q;
    tok_d       = 1'b0;
    ran_d       = ran_q;
    fin_d       = fin_q;
    ok_d        = ok_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    case (state_q)
      fts_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d   = fts_pkg::act_e'(action_i);
          pid_d   = task_pid_i;
          burst_d = cpu_burst_i;
          ios_d   = io_start_i;
          iod_d   = io_duration_i;
          rs_d    = read_slot_i;
          case (fts_pkg::act_e'(action_i))
            fts_pkg::ACT_LOAD: state_d = fts_pkg::S_LOAD;
            fts_pkg::ACT_KILL: begin
              tok_d   = 1'b1;
              state_d = fts_pkg::S_KILL;
            end
            fts_pkg::ACT_TICK: begin
              if (hv_q) begin
                state_d = fts_pkg::S_EXEC;
              end else begin
                tok_d   = 1'b1;
                state_d = fts_pkg::S_PICK1;
              end
            end
            default: state_d = fts_pkg::S_RESP;
          endcase
        end
      end
      fts_pkg::S_LOAD: begin
        ok_d = count_q < CW'(MaxTasks);
        if (count_q < CW'(MaxTasks)) count_d = count_q + CW'(1);
        state_d = fts_pkg::S_RESP;
      end
      fts_pkg::S_PICK1: begin
        if (tok[MaxTasks]) begin
          if (chain[MaxTasks].found) begin
            hv_d     = 1'b1;
            holder_d = idx[MaxTasks];
          end
          state_d = fts_pkg::S_EXEC;
        end
      end
      fts_pkg::S_EXEC: begin
        ran_d   = |ran_vec;
        fin_d   = |fin_vec;
        state_d = fts_pkg::S_AGE;
      end
      fts_pkg::S_AGE: begin
        if (tick_q != fts_pkg::TickMax) tick_d = tick_q + 32'd1;
        if (fin_q) hv_d = 1'b0;
        // pick a new holder when the CPU is free or its holder finished
        if (!hv_q || fin_q) begin
          tok_d   = 1'b1;
          state_d = fts_pkg::S_PICK2;
        end else begin
          state_d = fts_pkg::S_RESP;
        end
      end
      fts_pkg::S_PICK2: begin
        if (tok[MaxTasks]) begin
          if (chain[MaxTasks].found) begin
            hv_d     = 1'b1;
            holder_d = idx[MaxTasks];
          end
          state_d = fts_pkg::S_RESP;
        end
      end
      fts_pkg::S_KILL: begin
        if (tok[MaxTasks]) begin
          if (chain[MaxTasks].rel) hv_d = 1'b0;
          state_d = fts_pkg::S_RESP;
        end
      end
      fts_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          res_d          = '0;
          res_d.held     = hv_q;
          res_d.hslot    = hv_q ? 4'(holder_q) : 4'd0;
          res_d.all_done = &settled_vec;
          res_d.tick     = tick_q;
          case (act_q)
            fts_pkg::ACT_LOAD: res_d.ok = ok_q;
            fts_pkg::ACT_READ: begin
              res_d.ok = rd_ok;
              if (rd_ok) begin
                res_d.pid     = rd_view.pid;
                res_d.cpu     = rd_view.cpu;
                res_d.io      = rd_view.io;
                res_d.waiting = rd_view.wait_cnt;
                res_d.st      = 3'(rd_view.st);
                if (rd_view.st == fts_pkg::ST_DONE) begin
                  res_d.ta = rd_view.comp[31] ? 32'sh7FFF_FFFF : $signed(rd_view.comp);
                end else begin
                  res_d.ta = -32'sd1;
                end
              end
            end
            default: res_d.ok = 1'b1;
          endcase
          out_valid_d = 1'b1;
          state_d     = fts_pkg::S_IDLE;
        end
      end
      default: state_d = fts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fts_pkg::S_IDLE;
      count_q     <= '0;
      holder_q    <= '0;
      hv_q        <= 1'b0;
      tick_q      <= '0;
      tok_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      holder_q    <= holder_d;
      hv_q        <= hv_d;
      tick_q      <= tick_d;
      tok_q       <= tok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    pid_q   <= pid_d;
    burst_q <= burst_d;
    ios_q   <= ios_d;
    iod_q   <= iod_d;
    rs_q    <= rs_d;
    ran_q   <= ran_d;
    fin_q   <= fin_d;
    ok_q    <= ok_d;
    res_q   <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign ok_o               = res_q.ok;
  assign cpu_held_o         = res_q.held;
  assign holder_slot_o      = res_q.hslot;
  assign all_done_o         = res_q.all_done;
  assign tick_now_o         = res_q.tick;
  assign entry_pid_o        = res_q.pid;
  assign entry_cpu_o        = res_q.cpu;
  assign entry_io_o         = res_q.io;
  assign entry_turnaround_o = res_q.ta;
  assign entry_waiting_o    = res_q.waiting;
  assign entry_status_o     = res_q.st;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxTasks))
    else $error("task count beyond table size");

  a_holder_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> (CmpW'(holder_q) < CmpW'(count_q)))
    else $error("CPU holder is not a loaded slot");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one sweep token in the chain");

  a_one_runner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fts_pkg::S_IDLE) |-> ($countones(run_vec) <= 1))
    else $error("more than one slot running");

endmodule

`default_nettype wire
